// ===== hw/rtl/case_swap_dual_char_fifo_core_assert.svh =====
// Assertion macros shared by the dual character FIFO modules.
// Expects clk_i and rst_ni to be in scope where the macros are used.
`ifndef CASE_SWAP_DUAL_CHAR_FIFO_CORE_ASSERT_SVH
`define CASE_SWAP_DUAL_CHAR_FIFO_CORE_ASSERT_SVH

// Property checked at every rising edge of clk_i outside reset.
`define CSDF_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("csdf assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define CSDF_ASSERT_NEXT(label, ante, cons) \
  `CSDF_ASSERT(label, (ante) |=> (cons))

`endif

// ===== hw/rtl/csdf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the dual character FIFO.
// No dependencies; used by csdf_queue and the top level.
package csdf_pkg;

  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned CapW  = 7;
  localparam int unsigned CharW = 8;
  localparam int unsigned OccW  = 7;

  localparam logic [CapW-1:0] CapacityReset = 7'd64;

  localparam logic [CharW-1:0] CharUpperFirst = 8'h41;  // 'A'
  localparam logic [CharW-1:0] CharUpperLast  = 8'h5A;  // 'Z'
  localparam logic [CharW-1:0] CharLowerFirst = 8'h61;  // 'a'
  localparam logic [CharW-1:0] CharLowerLast  = 8'h7A;  // 'z'
  localparam logic [CharW-1:0] CaseBit        = 8'h20;

  localparam logic QueueUpper = 1'b0;
  localparam logic QueueLower = 1'b1;

  typedef enum logic [1:0] {
    ReqPush  = 2'd0,
    ReqPop   = 2'd1,
    ReqPeek  = 2'd2,
    ReqClear = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusFull      = 2'd1,
    StatusEmpty     = 2'd2,
    StatusNotLetter = 2'd3
  } status_e;

  // Per-queue command issued by the top level for one accepted request.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    logic rd;
  } queue_cmd_t;

  typedef struct packed {
    logic             letter;
    logic             sel;
    logic [CharW-1:0] ch;
  } char_class_t;

  // Upper-case letters go to the lower queue as lower case, and the reverse.
  function automatic char_class_t classify(logic [CharW-1:0] ch);
    char_class_t res;
    res.letter = 1'b0;
    res.sel    = QueueUpper;
    res.ch     = ch ^ CaseBit;
    if (ch >= CharUpperFirst && ch <= CharUpperLast) begin
      res.letter = 1'b1;
      res.sel    = QueueLower;
    end else if (ch >= CharLowerFirst && ch <= CharLowerLast) begin
      res.letter = 1'b1;
      res.sel    = QueueUpper;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/csdf_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module csdf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/csdf_queue.sv =====
`timescale 1ns / 1ps
// One circular character queue: head pointer, fill count and storage RAM.
// Depends on csdf_pkg, csdf_ram and the assertion macro header.
`include "case_swap_dual_char_fifo_core_assert.svh"
module csdf_queue #(
  parameter int unsigned Depth = csdf_pkg::QueueDepthDefault,
  localparam int unsigned AW = $clog2(Depth),
  localparam int unsigned CW = $clog2(Depth + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csdf_pkg::queue_cmd_t          cmd_i,
  input  logic [csdf_pkg::CharW-1:0]    wdata_i,
  output logic [CW-1:0]                 count_o,
  output logic [csdf_pkg::CharW-1:0]    rdata_o
);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_inc;

  // head + count stays below twice the depth, so one subtract wraps it.
  assign tail_sum = (AW+1)'(head_q) + (AW+1)'(count_q);
  assign tail     = (tail_sum >= (AW+1)'(Depth)) ? AW'(tail_sum - (AW+1)'(Depth))
                                                 : AW'(tail_sum);
  assign head_inc = (head_q == AW'(Depth - 1)) ? '0 : head_q + AW'(1);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    priority if (cmd_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  csdf_ram #(
    .Width (csdf_pkg::CharW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (tail),
    .wdata_i (wdata_i),
    .re_i    (cmd_i.rd),
    .raddr_i (head_q),
    .rdata_o (rdata_o)
  );

  assign count_o = count_q;

  `CSDF_ASSERT(a_count_bound, count_q <= CW'(Depth))
  `CSDF_ASSERT(a_pop_not_empty, cmd_i.pop |-> count_q != '0)
  `CSDF_ASSERT(a_push_has_room, cmd_i.push |-> count_q < CW'(Depth) && !cmd_i.pop)

endmodule

// ===== hw/rtl/case_swap_dual_char_fifo_core.sv =====
`timescale 1ns / 1ps
// Top level of the case-swapping dual character FIFO.
// Depends on csdf_pkg, csdf_queue and the assertion macro header.
//
// Usage: requests arrive on the slave stream. s_axis_tdata carries the
// character and s_axis_tuser carries the request kind and the queue select.
// Each request gives exactly one response on the master stream, carrying the
// status, the queue acted on, its occupancy afterwards and, for a peek, the
// head character. A push of an upper-case letter stores its lower-case form
// in the lower queue, and a lower-case letter goes to the upper queue in
// upper case; any other byte is refused with a not-a-letter status.
// The response is presented in the cycle after acceptance, and a new request
// is accepted in every cycle while the response side keeps up. This follows
// from the registered read port of the queue RAMs, which fetch the head
// character in the same edge that accepts the request. When the receiver
// stalls, the response is held and s_axis_tready drops only while the held
// response is not being taken, so a request may be accepted in the very
// cycle its predecessor's response is taken. The user must write the capacity
// register through cfg_we_i/cfg_wdata_i only while idle; the block does not
// enforce it. Reset empties both queues and sets the capacity to 64; the
// stores need no clearing pass, as unwritten entries are never returned.
`include "case_swap_dual_char_fifo_core_assert.svh"
module case_swap_dual_char_fifo_core #(
  parameter int unsigned QueueDepth = csdf_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: capacity register.
  input  logic                        cfg_we_i,
  input  logic [csdf_pkg::CapW-1:0]   cfg_wdata_i,
  // Request stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] char_in
  input  logic [2:0]                  s_axis_tuser,   // [1:0] req_type, [2] queue_sel
  // Response stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,   // [7:0] data_out, [14:8] occupancy
  output logic [2:0]                  m_axis_tuser    // [1:0] status, [2] queue_used
);

  localparam int unsigned CW   = $clog2(QueueDepth + 1);
  localparam int unsigned CMPW = (CW > csdf_pkg::CapW) ? CW : csdf_pkg::CapW;

  // Capacity register.
  logic [csdf_pkg::CapW-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= csdf_pkg::CapacityReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Request decode.
  logic                   s_fire;
  csdf_pkg::req_e         req;
  csdf_pkg::char_class_t  cls;
  logic                   sel;
  logic [CW-1:0]          up_count, lo_count, cnt_sel, cnt_next;
  logic [csdf_pkg::CharW-1:0] up_rdata, lo_rdata;
  logic                   full, empty;
  logic                   do_push, do_pop, do_clear, peek_ok;
  csdf_pkg::status_e      status_d;
  csdf_pkg::queue_cmd_t   up_cmd, lo_cmd;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign req    = csdf_pkg::req_e'(s_axis_tuser[1:0]);
  assign cls    = csdf_pkg::classify(s_axis_tdata);

  // A letter push picks its queue from the case; everything else obeys the select.
  assign sel     = (req == csdf_pkg::ReqPush && cls.letter) ? cls.sel : s_axis_tuser[2];
  assign cnt_sel = (sel == csdf_pkg::QueueLower) ? lo_count : up_count;
  assign empty   = (cnt_sel == '0);
  assign full    = (CMPW'(cnt_sel) >= CMPW'(cap_q)) || (cnt_sel >= CW'(QueueDepth));

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_clear = 1'b0;
    peek_ok  = 1'b0;
    status_d = csdf_pkg::StatusOk;
    cnt_next = cnt_sel;
    unique case (req)
      csdf_pkg::ReqPush: begin
        if (!cls.letter) begin
          status_d = csdf_pkg::StatusNotLetter;
        end else if (full) begin
          status_d = csdf_pkg::StatusFull;
        end else begin
          do_push  = 1'b1;
          cnt_next = cnt_sel + CW'(1);
        end
      end
      csdf_pkg::ReqPop: begin
        if (empty) begin
          status_d = csdf_pkg::StatusEmpty;
        end else begin
          do_pop   = 1'b1;
          cnt_next = cnt_sel - CW'(1);
        end
      end
      csdf_pkg::ReqPeek: begin
        if (empty) begin
          status_d = csdf_pkg::StatusEmpty;
        end else begin
          peek_ok = 1'b1;
        end
      end
      csdf_pkg::ReqClear: begin
        do_clear = 1'b1;
        cnt_next = '0;
      end
      default: begin
        status_d = csdf_pkg::StatusOk;
      end
    endcase
  end

  // Both RAMs read their head on every accepted request; the read data then
  // holds until the next acceptance, which keeps a stalled peek response intact.
  always_comb begin
    up_cmd.push  = s_fire && do_push  && (sel == csdf_pkg::QueueUpper);
    up_cmd.pop   = s_fire && do_pop   && (sel == csdf_pkg::QueueUpper);
    up_cmd.clear = s_fire && do_clear && (sel == csdf_pkg::QueueUpper);
    up_cmd.rd    = s_fire;
    lo_cmd.push  = s_fire && do_push  && (sel == csdf_pkg::QueueLower);
    lo_cmd.pop   = s_fire && do_pop   && (sel == csdf_pkg::QueueLower);
    lo_cmd.clear = s_fire && do_clear && (sel == csdf_pkg::QueueLower);
    lo_cmd.rd    = s_fire;
  end

  csdf_queue #(
    .Depth (QueueDepth)
  ) u_upper (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (up_cmd),
    .wdata_i (cls.ch),
    .count_o (up_count),
    .rdata_o (up_rdata)
  );

  csdf_queue #(
    .Depth (QueueDepth)
  ) u_lower (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (lo_cmd),
    .wdata_i (cls.ch),
    .count_o (lo_count),
    .rdata_o (lo_rdata)
  );

  // Response register.
  logic                       m_valid_q, m_valid_d;
  csdf_pkg::status_e          status_q;
  logic                       sel_q;
  logic [csdf_pkg::OccW-1:0]  occ_q;
  logic                       peek_ok_q;
  logic [csdf_pkg::CharW-1:0] data_out;

  assign s_axis_tready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (s_fire) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      status_q  <= status_d;
      sel_q     <= sel;
      occ_q     <= csdf_pkg::OccW'(cnt_next);
      peek_ok_q <= peek_ok;
    end
  end

  assign data_out = !peek_ok_q ? '0 :
                    (sel_q == csdf_pkg::QueueLower) ? lo_rdata : up_rdata;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, occ_q, data_out};
  assign m_axis_tuser  = {sel_q, status_q};

  `CSDF_ASSERT_NEXT(a_accept_gives_response, s_fire, m_valid_q)
  `CSDF_ASSERT_NEXT(a_non_letter_refused,
    s_fire && req == csdf_pkg::ReqPush && !cls.letter,
    status_q == csdf_pkg::StatusNotLetter)
  `CSDF_ASSERT_NEXT(a_clear_empties, s_fire && req == csdf_pkg::ReqClear,
    status_q == csdf_pkg::StatusOk && occ_q == '0)
  `CSDF_ASSERT(a_data_only_on_peek, m_valid_q && data_out != '0 |-> status_q == csdf_pkg::StatusOk)

endmodule

// ===== sim/tb_case_swap_dual_char_fifo_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for case_swap_dual_char_fifo_core.
// Depends on csdf_pkg and the block under test; needs no other files.

module tb_case_swap_dual_char_fifo_core;
  import csdf_pkg::*;

  localparam int unsigned Depth      = QueueDepthDefault;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned ErrShown   = 40;

  // One request as the sender offers it.
  typedef struct {
    req_e             kind;
    logic             sel;
    logic [CharW-1:0] ch;
  } fifo_req_t;

  // One response as the block should return it.
  typedef struct {
    status_e          status;
    logic [CharW-1:0] data;
    logic             qused;
    logic [OccW-1:0]  occ;
  } fifo_resp_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CapW-1:0]  cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;
  logic [2:0]       s_axis_tuser  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;
  logic [2:0]       m_axis_tuser;

  case_swap_dual_char_fifo_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Requests waiting to be offered, and responses owed by the block.
  fifo_req_t  req_backlog[$];
  fifo_resp_t owed_responses[$];

  // The testbench's own picture of both queues and of the capacity register.
  logic [CharW-1:0] shadow_store [2][Depth];
  int unsigned      shadow_head  [2] = '{0, 0};
  int unsigned      shadow_fill  [2] = '{0, 0};
  logic [CapW-1:0]  shadow_cap       = CapacityReset;

  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  int unsigned reqs_queued  = 0;
  int unsigned resps_seen   = 0;
  int unsigned full_seen    = 0;
  int unsigned empty_seen   = 0;
  int unsigned cap_writes   = 0;

  // Sender and receiver pacing.
  bit          req_taken  = 1'b0;
  bit          drain_hold = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned rdy_mode   = 0;
  int unsigned rdy_timer  = 0;
  fifo_req_t   next_req;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Works out the response to one accepted request and updates the shadow
  // queues. A push of an upper-case letter lands in the lower queue folded to
  // lower case, a lower-case letter lands in the upper queue in upper case,
  // and any other byte is refused against the queue that queue_sel names.
  function automatic void apply_request(input fifo_req_t rq);
    fifo_resp_t       r;
    logic             q;
    logic [CharW-1:0] folded;
    int unsigned      limit;
    r.status = StatusOk;
    r.data   = '0;
    q        = rq.sel;
    folded   = rq.ch;
    // A capacity above the store depth is clamped to the depth.
    limit    = (32'(shadow_cap) > Depth) ? Depth : 32'(shadow_cap);
    if (rq.kind == ReqPush) begin
      if (rq.ch >= CharUpperFirst && rq.ch <= CharUpperLast) begin
        q      = QueueLower;
        folded = rq.ch - CharUpperFirst + CharLowerFirst;
      end else if (rq.ch >= CharLowerFirst && rq.ch <= CharLowerLast) begin
        q      = QueueUpper;
        folded = rq.ch - CharLowerFirst + CharUpperFirst;
      end else begin
        r.status = StatusNotLetter;
      end
    end
    case (rq.kind)
      ReqPush: begin
        // A count at or above the capacity refuses the push, which also
        // covers a capacity of zero and one lowered below the count.
        if (r.status == StatusOk) begin
          if (shadow_fill[q] >= limit) begin
            r.status = StatusFull;
          end else begin
            shadow_store[q][(shadow_head[q] + shadow_fill[q]) % Depth] = folded;
            shadow_fill[q]++;
          end
        end
      end
      ReqPop: begin
        if (shadow_fill[q] == 0) begin
          r.status = StatusEmpty;
        end else begin
          shadow_head[q] = (shadow_head[q] + 1) % Depth;
          shadow_fill[q]--;
        end
      end
      ReqPeek: begin
        if (shadow_fill[q] == 0) begin
          r.status = StatusEmpty;
        end else begin
          r.data = shadow_store[q][shadow_head[q]];
        end
      end
      default: begin
        shadow_head[q] = 0;
        shadow_fill[q] = 0;
      end
    endcase
    r.qused = q;
    r.occ   = OccW'(shadow_fill[q]);
    owed_responses.push_back(r);
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= ErrShown) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    end
  endfunction

  // Monitor: at each rising edge take a response if one is handed over, then
  // note a request if one is accepted. The response of a request can appear
  // at the earliest in the cycle after it is accepted.
  always @(posedge clk_i) begin
    fifo_req_t  seen;
    fifo_resp_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t ns: timeout, %0d responses still owed", $time, owed_responses.size());
      $display("tb_case_swap_dual_char_fifo_core failed");
      $finish;
    end
    req_taken = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        resps_seen++;
        if (owed_responses.size() == 0) begin
          errors++;
          $display("%0t ns: response with none owed, tuser %h tdata %h", $time,
                   m_axis_tuser, m_axis_tdata);
        end else begin
          want = owed_responses.pop_front();
          if (want.status == StatusFull) full_seen++;
          if (want.status == StatusEmpty) empty_seen++;
          check_field("status", 32'(want.status), 32'(m_axis_tuser[1:0]));
          check_field("queue_used", 32'(want.qused), 32'(m_axis_tuser[2]));
          check_field("data_out", 32'(want.data), 32'(m_axis_tdata[7:0]));
          check_field("occupancy", 32'(want.occ), 32'(m_axis_tdata[14:8]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen.kind = req_e'(s_axis_tuser[1:0]);
        seen.sel  = s_axis_tuser[2];
        seen.ch   = s_axis_tdata;
        apply_request(seen);
        req_taken = 1'b1;
      end
    end
  end

  // Driver: at each falling edge offer the next request once the current one
  // has gone. Requests come in bursts with gaps between them; now and then the
  // sender holds off until every owed response has come back.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (drain_hold && owed_responses.size() != 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (req_backlog.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          drain_hold = 1'b0;
          next_req = req_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_req.ch;
          s_axis_tuser  <= {next_req.sel, next_req.kind};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            drain_hold = ($urandom_range(0, 29) == 0);
          end
        end
      end
      // The receiver keeps a stall pattern for a while and then picks another:
      // always ready, coin toss, mostly stalled, or following bit 1 of the cycle count.
      if (rdy_timer == 0) begin
        rdy_timer = $urandom_range(20, 120);
        rdy_mode  = $urandom_range(0, 3);
      end
      rdy_timer--;
      case (rdy_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= cycle_count[1];
      endcase
    end
  end

  task automatic queue_req(input req_e kind, input logic sel, input logic [7:0] ch);
    fifo_req_t rq;
    rq.kind = kind;
    rq.sel  = sel;
    rq.ch   = ch;
    req_backlog.push_back(rq);
    reqs_queued++;
  endtask

  function automatic logic [7:0] pick_letter(input logic upper);
    return (upper ? CharUpperFirst : CharLowerFirst) + 8'($urandom_range(0, 25));
  endfunction

  // Mostly letters of either case, with the odd arbitrary byte.
  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return pick_letter(1'b1);
    if (roll < 90) return pick_letter(1'b0);
    return 8'($urandom_range(0, 255));
  endfunction

  // Waits until nothing is offered or owed, then lets the pipeline settle.
  task automatic wait_quiet();
    while (req_backlog.size() != 0 || s_axis_tvalid || owed_responses.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    wait_quiet();
    @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    shadow_cap = value;
    cap_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic for one capacity setting. Most of it comes as runs that
  // fill one queue or drain one, so that full and empty queues are reached
  // often; the rest is mixed traffic, clears and plain noise.
  task automatic random_phase(input int unsigned amount);
    int unsigned start;
    int unsigned len;
    int unsigned roll;
    int unsigned k;
    logic        side;
    start = reqs_queued;
    while (reqs_queued - start < amount) begin
      roll = $urandom_range(0, 99);
      side = 1'($urandom_range(0, 1));
      if (roll < 30) begin
        len = $urandom_range(1, 70);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            queue_req(ReqPeek, ~side, pick_char());
          end else begin
            queue_req(ReqPush, 1'($urandom_range(0, 1)), pick_letter(side));
          end
        end
      end else if (roll < 55) begin
        len = $urandom_range(1, 70);
        for (k = 0; k < len; k++) begin
          queue_req(($urandom_range(0, 3) == 0) ? ReqPeek : ReqPop, side, pick_char());
        end
      end else if (roll < 82) begin
        len = $urandom_range(5, 30);
        for (k = 0; k < len; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < 50)      queue_req(ReqPush, 1'($urandom_range(0, 1)), pick_char());
          else if (roll < 75) queue_req(ReqPop, 1'($urandom_range(0, 1)), pick_char());
          else if (roll < 93) queue_req(ReqPeek, 1'($urandom_range(0, 1)), pick_char());
          else                queue_req(ReqClear, 1'($urandom_range(0, 1)), pick_char());
        end
      end else if (roll < 90) begin
        queue_req(ReqClear, side, pick_char());
        len = $urandom_range(1, 10);
        for (k = 0; k < len; k++) queue_req(ReqPush, side, pick_letter(~side));
      end else begin
        len = $urandom_range(1, 10);
        for (k = 0; k < len; k++) begin
          queue_req(req_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)));
        end
      end
    end
    // Leave one queue well stocked so that a lower capacity in the next
    // setting starts below the count.
    side = 1'($urandom_range(0, 1));
    for (k = 0; k < 40; k++) queue_req(ReqPush, 1'b0, pick_letter(side));
  endtask

  initial begin
    logic [CapW-1:0] caps[10];
    int unsigned     p;
    caps = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd64, 7'd3, 7'd100, 7'd0, 7'd0, 7'd2};
    caps[7] = CapW'($urandom_range(2, 63));
    caps[8] = CapW'($urandom_range(1, 64));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests at the reset capacity: empty queues, the letters at
    // both ends of each case, the bytes just outside them, the byte extremes,
    // peek and pop of held letters, and clears of occupied and empty queues.
    queue_req(ReqPeek, QueueUpper, 8'h00);
    queue_req(ReqPop, QueueLower, 8'hFF);
    queue_req(ReqPush, QueueUpper, CharUpperFirst);
    queue_req(ReqPush, QueueUpper, CharUpperLast);
    queue_req(ReqPush, QueueLower, CharLowerFirst);
    queue_req(ReqPush, QueueLower, CharLowerLast);
    queue_req(ReqPush, QueueUpper, CharUpperFirst - 8'd1);
    queue_req(ReqPush, QueueLower, CharUpperLast + 8'd1);
    queue_req(ReqPush, QueueUpper, CharLowerFirst - 8'd1);
    queue_req(ReqPush, QueueLower, CharLowerLast + 8'd1);
    queue_req(ReqPush, QueueLower, 8'h00);
    queue_req(ReqPush, QueueUpper, 8'hFF);
    queue_req(ReqPeek, QueueLower, 8'h00);
    queue_req(ReqPop, QueueLower, 8'h00);
    queue_req(ReqPeek, QueueLower, 8'h00);
    queue_req(ReqPeek, QueueUpper, 8'hFF);
    queue_req(ReqClear, QueueUpper, 8'h00);
    queue_req(ReqPeek, QueueUpper, 8'h00);
    queue_req(ReqPop, QueueUpper, 8'h00);
    queue_req(ReqClear, QueueLower, 8'hFF);
    queue_req(ReqClear, QueueLower, 8'h00);
    queue_req(ReqPop, QueueLower, 8'hFF);

    // Each setting is written only once the block has gone quiet.
    for (p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      random_phase(135);
    end

    wait_quiet();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d requests and %0d responses over %0d capacity settings,",
             reqs_queued, resps_seen, cap_writes);
    $display("with %0d refused pushes into full queues and %0d empty-queue accesses.",
             full_seen, empty_seen);
    if (errors == 0) begin
      $display("tb_case_swap_dual_char_fifo_core passed");
    end else begin
      $display("tb_case_swap_dual_char_fifo_core failed");
    end
    $finish;
  end

endmodule
